// File: rtl/core/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

  localparam int NAME_MAX_LEN_DEF  = 32;
  localparam int MAX_PARAMS_DEF    = 16;
  localparam int VALUE_MAX_LEN_DEF = 64;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_USCR  = 8'h5F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef enum logic [2:0] {
    ROLE_SEP = 3'd0,
    ROLE_CMD = 3'd1,
    ROLE_OPT = 3'd2,
    ROLE_VAL = 3'd3,
    ROLE_IGN = 3'd4
  } role_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_ERR   = 2'd2
  } status_t;

  typedef struct packed {
    logic add;
    logic first;
  } vcmd_t;

  typedef struct packed {
    logic        ovf;
    logic        is_num;
    logic [31:0] num;
  } vres_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[CH_UA:CH_UZ]}) || (c inside {[CH_LA:CH_LZ]});
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_dig(c) || (c == CH_DASH) || (c == CH_USCR);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (is_dig(c)) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c inside {[CH_UA:CH_UF]}) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end else if (c inside {[CH_LA:CH_LF]}) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/clt_if.sv
`timescale 1ns / 1ps

interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       last;

  modport source (output valid, ch, has_char, last, input ready);
  modport sink   (input valid, ch, has_char, last, output ready);
endinterface

interface clt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic [2:0]  char_role;
  logic [3:0]  param_index;
  logic        param_start;
  logic        param_is_option;
  logic        value_done;
  logic        value_is_number;
  logic [31:0] value_num;
  logic        line_done;
  logic [1:0]  line_status;
  logic [4:0]  param_count;

  modport source (
    output valid, out_char, char_role, param_index, param_start, param_is_option,
           value_done, value_is_number, value_num, line_done, line_status, param_count,
    input  ready
  );
  modport sink (
    input  valid, out_char, char_role, param_index, param_start, param_is_option,
           value_done, value_is_number, value_num, line_done, line_status, param_count,
    output ready
  );
endinterface

// File: rtl/core/clt_value.sv
`timescale 1ns / 1ps

module clt_value import clt_pkg::*; #(
  parameter int VALUE_MAX_LEN = VALUE_MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  vcmd_t      cmd,
  input  logic [7:0] ch,
  output vres_t      res
);

  localparam int LW = $clog2(VALUE_MAX_LEN);

  logic [LW-1:0] len_r, len_nxt, pos;
  logic [31:0]   dec_r, dec_nxt, dec_b;
  logic [31:0]   hex_r, hex_nxt, hex_b;
  logic          dig_r, dig_nxt, dig_b;
  logic          zero_r, zero_nxt, zero_b;
  logic          hexm_r, hexm_nxt, hexm_b;
  logic          stop_r, stop_nxt, stop_b;
  logic [4:0]    hv;

  always_comb begin
    pos     = cmd.first ? '0 : len_r;
    res.ovf = (pos >= LW'(VALUE_MAX_LEN - 1));
    hv      = hex_val(ch);

    if (pos == '0) begin
      dec_b  = '0;
      hex_b  = '0;
      dig_b  = 1'b1;
      zero_b = (ch == CH_0);
      hexm_b = 1'b0;
      stop_b = 1'b0;
    end else begin
      dec_b  = dec_r;
      hex_b  = hex_r;
      dig_b  = dig_r;
      zero_b = zero_r;
      hexm_b = hexm_r;
      stop_b = stop_r;
    end

    dec_nxt  = dec_b;
    hex_nxt  = hex_b;
    dig_nxt  = dig_b;
    zero_nxt = zero_b;
    hexm_nxt = hexm_b;
    stop_nxt = stop_b;

    if (pos == LW'(1) && zero_b && ch == CH_X) begin
      hexm_nxt = 1'b1;
    end else if (hexm_b && pos > LW'(1) && !stop_b) begin
      if (!hv[4]) begin
        stop_nxt = 1'b1;
      end else if (hex_b[31:28] != 4'd0) begin
        hex_nxt = '1;
      end else begin
        hex_nxt = {hex_b[27:0], hv[3:0]};
      end
    end

    if (is_dig(ch)) begin
      dec_nxt = {dec_b[28:0], 3'b000} + {dec_b[30:0], 1'b0} + 32'(ch - CH_0);
    end else begin
      dig_nxt = 1'b0;
    end

    len_nxt = LW'(pos + 1'b1);

    // view of the value after this transfer
    if (cmd.add) begin
      res.is_num = hexm_nxt || dig_nxt;
      res.num    = hexm_nxt ? hex_nxt : (dig_nxt ? dec_nxt : '0);
    end else begin
      res.is_num = hexm_r || dig_r;
      res.num    = hexm_r ? hex_r : (dig_r ? dec_r : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      dec_r  <= '0;
      hex_r  <= '0;
      dig_r  <= 1'b1;
      zero_r <= 1'b0;
      hexm_r <= 1'b0;
      stop_r <= 1'b0;
    end else if (cmd.add) begin
      len_r  <= len_nxt;
      dec_r  <= dec_nxt;
      hex_r  <= hex_nxt;
      dig_r  <= dig_nxt;
      zero_r <= zero_nxt;
      hexm_r <= hexm_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

// File: rtl/core/command_line_tokenizer_top.sv
`timescale 1ns / 1ps

// Command line tokenizer.
// in_if carries one character per transfer (ch, has_char, last); last closes
// the line. out_if returns exactly one result per input transfer: the role
// of the character, its parameter index, value completion with the decoded
// number, and on the last transfer the line status and parameter count.
// The result of a transfer is shown on out_if in the next cycle. Throughput
// is one character per cycle; the parser state and the value accumulators
// update in the same cycle the character is taken.
// The output register lets in_if accept a new character while a result is
// being taken; when out_if stalls with a result pending, in_if.ready drops
// until that result is transferred.
// After reset, and after every line end, the parser waits for the first
// character of a command name with no parameters counted.
module command_line_tokenizer_top import clt_pkg::*; #(
  parameter int NAME_MAX_LEN  = NAME_MAX_LEN_DEF,
  parameter int MAX_PARAMS    = MAX_PARAMS_DEF,
  parameter int VALUE_MAX_LEN = VALUE_MAX_LEN_DEF
) (
  input logic     clk,
  input logic     rst_n,
  clt_in_if.sink  in_if,
  clt_out_if.source out_if
);

  localparam int NW = $clog2(NAME_MAX_LEN);
  localparam int PW = $clog2(MAX_PARAMS + 1);

  typedef enum logic [3:0] {
    S_HEAD, S_NAME, S_DETECT, S_VALUE, S_DASH1, S_DASH2, S_OPT, S_GAP, S_WANTVAL, S_ERROR
  } state_t;

  typedef struct packed {
    logic [7:0]  out_char;
    role_t       role;
    logic [3:0]  param_index;
    logic        param_start;
    logic        param_is_option;
    logic        value_done;
    logic        value_is_number;
    logic [31:0] value_num;
    logic        line_done;
    status_t     status;
    logic [4:0]  param_count;
  } result_t;

  state_t        state_r, st_nxt;
  logic [NW-1:0] name_len_r, nl_nxt;
  logic [PW-1:0] pf_r, pf_nxt;
  logic          opt_r, opt_nxt;
  logic          out_valid_r;
  result_t       out_r, res_nxt;

  logic          accept;
  logic          ok, v_add, vdone, start;
  logic          pf_full;
  role_t         role;
  status_t       status;
  logic [7:0]    c;
  vcmd_t         vcmd;
  vres_t         vres;

  assign c           = in_if.ch;
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign pf_full     = (pf_r >= PW'(MAX_PARAMS));

  assign vcmd.first  = (state_r != S_VALUE);
  assign vcmd.add    = v_add && accept;

  clt_value #(
    .VALUE_MAX_LEN (VALUE_MAX_LEN)
  ) u_value (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (vcmd),
    .ch    (c),
    .res   (vres)
  );

  always_comb begin
    st_nxt  = state_r;
    nl_nxt  = name_len_r;
    pf_nxt  = pf_r;
    opt_nxt = opt_r;
    role    = ROLE_SEP;
    start   = 1'b0;
    vdone   = 1'b0;
    ok      = 1'b1;
    v_add   = 1'b0;
    status  = STAT_OK;

    if (in_if.has_char) begin
      case (state_r)
        S_HEAD: begin
          if (is_alpha(c)) begin
            nl_nxt = NW'(1);
            role   = ROLE_CMD;
            st_nxt = S_NAME;
          end else begin
            ok = 1'b0;
          end
        end
        S_NAME, S_OPT: begin
          if (is_word(c)) begin
            if (name_len_r >= NW'(NAME_MAX_LEN - 1)) begin
              ok = 1'b0;
            end else begin
              nl_nxt = NW'(name_len_r + 1'b1);
              role   = (state_r == S_NAME) ? ROLE_CMD : ROLE_OPT;
            end
          end else if (c == CH_SPACE) begin
            st_nxt = (state_r == S_NAME) ? S_DETECT : S_GAP;
          end else if (state_r == S_OPT && c == CH_EQ) begin
            st_nxt = S_WANTVAL;
          end else begin
            ok = 1'b0;
          end
        end
        S_DETECT: begin
          if (c == CH_SPACE) begin
            st_nxt = S_DETECT;
          end else if (c == CH_DASH) begin
            st_nxt = S_DASH1;
          end else if (is_word(c) && !pf_full) begin
            pf_nxt  = PW'(pf_r + 1'b1);
            opt_nxt = 1'b0;
            v_add   = 1'b1;
            role    = ROLE_VAL;
            start   = 1'b1;
            st_nxt  = S_VALUE;
          end else begin
            ok = 1'b0;
          end
        end
        S_VALUE: begin
          if (is_word(c) && !vres.ovf) begin
            v_add = 1'b1;
            role  = ROLE_VAL;
          end else if (c == CH_SPACE) begin
            vdone  = 1'b1;
            st_nxt = S_DETECT;
          end else begin
            ok = 1'b0;
          end
        end
        S_DASH1, S_DASH2: begin
          if (state_r == S_DASH1 && c == CH_DASH) begin
            st_nxt = S_DASH2;
          end else if (is_alpha(c) && !pf_full) begin
            pf_nxt  = PW'(pf_r + 1'b1);
            opt_nxt = 1'b1;
            nl_nxt  = NW'(1);
            role    = ROLE_OPT;
            start   = 1'b1;
            st_nxt  = S_OPT;
          end else begin
            ok = 1'b0;
          end
        end
        S_GAP: begin
          if (c == CH_SPACE) begin
            st_nxt = S_GAP;
          end else if (c == CH_DASH) begin
            st_nxt = S_DASH1;
          end else if (c == CH_EQ) begin
            st_nxt = S_WANTVAL;
          end else if (is_word(c)) begin
            v_add  = 1'b1;
            role   = ROLE_VAL;
            st_nxt = S_VALUE;
          end else begin
            ok = 1'b0;
          end
        end
        S_WANTVAL: begin
          if (c == CH_SPACE) begin
            st_nxt = S_WANTVAL;
          end else if (is_word(c)) begin
            v_add  = 1'b1;
            role   = ROLE_VAL;
            st_nxt = S_VALUE;
          end else begin
            ok = 1'b0;
          end
        end
        default: ok = 1'b0;
      endcase

      if (!ok) begin
        st_nxt = S_ERROR;
        role   = ROLE_IGN;
      end
    end

    if (in_if.last && st_nxt == S_VALUE) begin
      vdone  = 1'b1;
      st_nxt = S_DETECT;
    end

    if (in_if.last) begin
      if (st_nxt == S_ERROR || st_nxt == S_DASH2) begin
        status = STAT_ERR;
      end else if (st_nxt == S_HEAD) begin
        status = STAT_EMPTY;
      end else begin
        status = STAT_OK;
      end
    end

    res_nxt.out_char        = in_if.has_char ? c : 8'd0;
    res_nxt.role            = role;
    res_nxt.param_index     = (pf_nxt != '0) ? 4'(pf_nxt - 1'b1) : 4'd0;
    res_nxt.param_start     = start;
    res_nxt.param_is_option = (pf_nxt != '0) && opt_nxt;
    res_nxt.value_done      = vdone;
    res_nxt.value_is_number = vdone && vres.is_num;
    res_nxt.value_num       = (vdone && vres.is_num) ? vres.num : 32'd0;
    res_nxt.line_done       = in_if.last;
    res_nxt.status          = status;
    res_nxt.param_count     = (in_if.last && status == STAT_OK) ? 5'(pf_nxt) : 5'd0;

    // line end returns to the idle parse state
    if (in_if.last) begin
      st_nxt  = S_HEAD;
      nl_nxt  = '0;
      pf_nxt  = '0;
      opt_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HEAD;
      name_len_r  <= '0;
      pf_r        <= '0;
      opt_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      state_r     <= st_nxt;
      name_len_r  <= nl_nxt;
      pf_r        <= pf_nxt;
      opt_r       <= opt_nxt;
      out_valid_r <= 1'b1;
      out_r       <= res_nxt;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.out_char        = out_r.out_char;
  assign out_if.char_role       = out_r.role;
  assign out_if.param_index     = out_r.param_index;
  assign out_if.param_start     = out_r.param_start;
  assign out_if.param_is_option = out_r.param_is_option;
  assign out_if.value_done      = out_r.value_done;
  assign out_if.value_is_number = out_r.value_is_number;
  assign out_if.value_num       = out_r.value_num;
  assign out_if.line_done       = out_r.line_done;
  assign out_if.line_status     = out_r.status;
  assign out_if.param_count     = out_r.param_count;

endmodule

// File: rtl/core/clt_checker.sv
`timescale 1ns / 1ps

module clt_checker import clt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_char,
  input logic [2:0]  char_role,
  input logic        param_start,
  input logic        value_done,
  input logic        value_is_number,
  input logic [31:0] value_num
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(value_num))
    else $error("result changed while stalled");

  // every transfer in gives a result next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_num_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !value_done |-> !value_is_number && value_num == 32'd0)
    else $error("number reported without value end");

  a_start_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && param_start |-> char_role == ROLE_OPT || char_role == ROLE_VAL)
    else $error("parameter opened on wrong role");

endmodule

bind command_line_tokenizer_top clt_checker u_clt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_char        (out_if.out_char),
  .char_role       (out_if.char_role),
  .param_start     (out_if.param_start),
  .value_done      (out_if.value_done),
  .value_is_number (out_if.value_is_number),
  .value_num       (out_if.value_num)
);
